### src/bmcd_pkg.sv
// Shared types and constants of the battery monitor with charge detection.
package bmcd_pkg;

    localparam int VOLT_W = 13;
    localparam int PCT_W = 7;
    localparam int TIME_W = 32;
    localparam int READ_W = 12;
    localparam int CAL_W = 16;
    localparam int RUN_W = 8;
    localparam int TMO_W = 16;
    localparam int ACT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int NUM_W = 21;
    localparam int DEN_W = 14;
    localparam int DIV_CNT_W = 5;

    localparam logic [TIME_W-1:0] TREND_AGE_MS = 32'd90000;
    localparam logic [VOLT_W:0] TREND_RISE_MV = 14'd30;
    localparam logic [VOLT_W:0] TREND_FALL_MV = 14'd90;
    localparam logic [VOLT_W-1:0] TREND_HIGH_MV = 13'd4000;
    localparam logic [VOLT_W-1:0] SPIKE_MV = 13'd500;
    localparam logic [VOLT_W:0] PLUG_MV = 14'd250;
    localparam logic [VOLT_W:0] UNPLUG_MV = 14'd200;
    localparam logic [VOLT_W-1:0] CRITICAL_MV = 13'd3000;
    localparam logic [TMO_W-1:0] MS_PER_MIN = 16'd60000;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [7:0] PCT_SCALE = 8'd200;
    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    typedef enum logic [ACT_W-1:0] {
        ACT_UPDATE   = 3'd0,
        ACT_QUERY    = 3'd1,
        ACT_REFRESH  = 3'd2,
        ACT_ACTIVITY = 3'd3,
        ACT_INIT     = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_MV      = 3'd0,
        CFG_EMPTY_MV     = 3'd1,
        CFG_CALIBRATION  = 3'd2,
        CFG_HIST_INTV    = 3'd3,
        CFG_CACHE_DUR    = 3'd4,
        CFG_GRACE        = 3'd5,
        CFG_CRIT_CONFIRM = 3'd6,
        CFG_SLEEP_TMO    = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUSH_STALE,
        ST_PUSH,
        ST_TREND,
        ST_CRIT_STALE,
        ST_CRITICAL,
        ST_SLEEP,
        ST_INIT_FILL,
        ST_MEAS_MUL,
        ST_MEAS_APPLY,
        ST_MEAS_PCT,
        ST_MEAS_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_PUSH,
        PH_CRIT,
        PH_DONE,
        PH_INIT
    } phase_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic apply;
        logic pct_init;
        logic div_step;
        logic push;
        logic trend;
        logic crit;
        logic sleep;
        logic activity;
        logic init_fill;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic push_due;
        logic stale;
        logic div_done;
    } status_t;

endpackage

### src/bmcd_in_if.sv
// Input channel carrying one monitor transaction.
interface bmcd_in_if;
    logic valid;
    logic ready;
    logic [2:0] action;
    logic [31:0] now_ms;
    logic [11:0] reading_mv;

    modport source (output valid, output action, output now_ms, output reading_mv, input ready);
    modport sink (input valid, input action, input now_ms, input reading_mv, output ready);
endinterface

### src/bmcd_out_if.sv
// Output channel carrying one status result transaction.
interface bmcd_out_if;
    logic valid;
    logic ready;
    logic [12:0] voltage_mv;
    logic [6:0] percent;
    logic charging;
    logic shutdown_request;
    logic sleep_request;

    modport source (output valid, output voltage_mv, output percent, output charging,
                    output shutdown_request, output sleep_request, input ready);
    modport sink (input valid, input voltage_mv, input percent, input charging,
                  input shutdown_request, input sleep_request, output ready);
endinterface

### src/battery_monitor_charge_detect.sv
// Top level of the battery monitor with charge detection.
// Each input transaction returns exactly one status result transaction. One transaction
// is worked on at a time; a status query on a fresh cache is the shortest, and a
// periodic update that measures twice is the longest. A measurement runs the multiply,
// apply and percentage set-up steps and then the serial restoring divider that produces
// the percentage one quotient bit per cycle. A new transaction is taken while the
// previous result still waits in the output register.
module battery_monitor_charge_detect #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bmcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmcd_pkg::CFG_DATA_W-1:0]   cfg_data,
    bmcd_in_if.sink                           item,
    bmcd_out_if.source                        result
);
    import bmcd_pkg::*;

    cmd_t cmd;
    status_t status;

    bmcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bmcd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_action            (item.action),
        .in_now_ms            (item.now_ms),
        .in_reading_mv        (item.reading_mv),
        .cmd                  (cmd),
        .status               (status),
        .out_voltage_mv       (result.voltage_mv),
        .out_percent          (result.percent),
        .out_charging         (result.charging),
        .out_shutdown_request (result.shutdown_request),
        .out_sleep_request    (result.sleep_request)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("A second transaction was taken while one is in progress.");

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.percent <= PCT_FULL)
        else $error("Percentage above full.");

    a_requests_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.shutdown_request && result.sleep_request))
        else $error("Shutdown and sleep requested together.");

    a_sleep_not_charging: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.sleep_request |-> !result.charging)
        else $error("Sleep requested while charging.");

endmodule

### src/bmcd_ctrl.sv
// Controller state machine that sequences the steps of one transaction.
module bmcd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bmcd_pkg::status_t status,
    output bmcd_pkg::cmd_t    cmd
);
    import bmcd_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.action == ACT_UPDATE)
                begin
                    state_next = status.push_due ? ST_PUSH_STALE : ST_CRIT_STALE;
                end
                else if (status.action == ACT_QUERY)
                begin
                    phase_next = PH_DONE;
                    state_next = status.stale ? ST_MEAS_MUL : ST_FINISH;
                end
                else if (status.action == ACT_REFRESH)
                begin
                    phase_next = PH_DONE;
                    state_next = ST_MEAS_MUL;
                end
                else if (status.action == ACT_ACTIVITY)
                begin
                    cmd.activity = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (status.action == ACT_INIT)
                begin
                    phase_next = PH_INIT;
                    state_next = ST_MEAS_MUL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PUSH_STALE:
            begin
                phase_next = PH_PUSH;
                state_next = status.stale ? ST_MEAS_MUL : ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                state_next = ST_TREND;
            end
            ST_TREND:
            begin
                cmd.trend = 1'b1;
                state_next = ST_CRIT_STALE;
            end
            ST_CRIT_STALE:
            begin
                phase_next = PH_CRIT;
                state_next = status.stale ? ST_MEAS_MUL : ST_CRITICAL;
            end
            ST_CRITICAL:
            begin
                cmd.crit = 1'b1;
                state_next = ST_SLEEP;
            end
            ST_SLEEP:
            begin
                cmd.sleep = 1'b1;
                state_next = ST_FINISH;
            end
            ST_INIT_FILL:
            begin
                cmd.init_fill = 1'b1;
                state_next = ST_FINISH;
            end
            ST_MEAS_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_MEAS_APPLY;
            end
            ST_MEAS_APPLY:
            begin
                cmd.apply = 1'b1;
                state_next = ST_MEAS_PCT;
            end
            ST_MEAS_PCT:
            begin
                cmd.pct_init = 1'b1;
                state_next = ST_MEAS_DIV;
            end
            ST_MEAS_DIV:
            begin
                if (!status.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_PUSH: state_next = ST_PUSH;
                        PH_CRIT: state_next = ST_CRITICAL;
                        PH_INIT: state_next = ST_INIT_FILL;
                        PH_DONE: state_next = ST_FINISH;
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### src/bmcd_datapath.sv
// Datapath holding configuration, cached status, history and the percentage divider.
module bmcd_datapath #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bmcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [bmcd_pkg::ACT_W-1:0]          in_action,
    input  logic [bmcd_pkg::TIME_W-1:0]         in_now_ms,
    input  logic [bmcd_pkg::READ_W-1:0]         in_reading_mv,
    input  bmcd_pkg::cmd_t                      cmd,
    output bmcd_pkg::status_t                   status,
    output logic [bmcd_pkg::VOLT_W-1:0]         out_voltage_mv,
    output logic [bmcd_pkg::PCT_W-1:0]          out_percent,
    output logic                                out_charging,
    output logic                                out_shutdown_request,
    output logic                                out_sleep_request
);
    import bmcd_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

    logic [VOLT_W-1:0] full_reg, empty_reg;
    logic [CAL_W-1:0] cal_reg;
    logic [TIME_W-1:0] hist_intv_reg, cache_dur_reg, grace_reg;
    logic [RUN_W-1:0] confirm_reg;
    logic [TMO_W-1:0] sleep_tmo_reg;
    logic [TIME_W-1:0] sleep_limit_reg;

    logic [ACT_W-1:0] action_reg;
    logic [TIME_W-1:0] now_reg;
    logic [READ_W-1:0] reading_reg;
    logic [READ_W+CAL_W-1:0] prod_reg;

    logic [VOLT_W-1:0] cv_reg, cv_next;
    logic [PCT_W-1:0] pct_reg, pct_next;
    logic chg_reg, chg_next;
    logic [VOLT_W-1:0] prior_reg, prior_next;
    logic [VOLT_W-1:0] lg_reg, lg_next;
    logic [TIME_W-1:0] read_time_reg, read_time_next;
    logic [TIME_W-1:0] push_time_reg, push_time_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [VOLT_W-1:0] hist_v_reg [HISTORY_DEPTH];
    logic [VOLT_W-1:0] hist_v_next [HISTORY_DEPTH];
    logic [TIME_W-1:0] hist_t_reg [HISTORY_DEPTH];
    logic [TIME_W-1:0] hist_t_next [HISTORY_DEPTH];
    logic [TIME_W-1:0] seen_reg, seen_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [TIME_W-1:0] act_time_reg, act_time_next;
    logic shut_reg, shut_next;
    logic sleep_reg, sleep_next;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [VOLT_W-1:0] out_v_reg;
    logic [PCT_W-1:0] out_pct_reg;
    logic out_chg_reg, out_shut_reg, out_sleep_reg;

    logic [READ_W+CAL_W:0] round_sum;
    logic [READ_W+CAL_W-13:0] raw_v;
    logic [VOLT_W-1:0] clamp_v, meas_v, spike_diff, span;
    logic [DEN_W:0] trial;
    logic [SLOT_W-1:0] slot_eff;
    logic [RUN_W-1:0] run_inc;
    logic [VOLT_W-1:0] old_v;
    logic [TIME_W-1:0] old_t;
    logic meas_chg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 13'd4200;
            empty_reg <= 13'd3300;
            cal_reg <= 16'd16384;
            hist_intv_reg <= 32'd30000;
            cache_dur_reg <= 32'd5000;
            grace_reg <= 32'd60000;
            confirm_reg <= 8'd3;
            sleep_tmo_reg <= '0;
            sleep_limit_reg <= '0;
        end
        else
        begin
            sleep_limit_reg <= sleep_tmo_reg * MS_PER_MIN;
            if (cfg_wr_en)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_FULL_MV:      full_reg <= cfg_data[VOLT_W-1:0];
                    CFG_EMPTY_MV:     empty_reg <= cfg_data[VOLT_W-1:0];
                    CFG_CALIBRATION:  cal_reg <= cfg_data[CAL_W-1:0];
                    CFG_HIST_INTV:    hist_intv_reg <= cfg_data;
                    CFG_CACHE_DUR:    cache_dur_reg <= cfg_data;
                    CFG_GRACE:        grace_reg <= cfg_data;
                    CFG_CRIT_CONFIRM: confirm_reg <= cfg_data[RUN_W-1:0];
                    CFG_SLEEP_TMO:    sleep_tmo_reg <= cfg_data[TMO_W-1:0];
                    default:          full_reg <= full_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= in_action;
            now_reg <= in_now_ms;
            reading_reg <= in_reading_mv;
        end
        if (cmd.mul)
        begin
            prod_reg <= reading_reg * cal_reg;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        if (cmd.load_out)
        begin
            out_v_reg <= cv_reg;
            out_pct_reg <= pct_reg;
            out_chg_reg <= chg_reg;
            out_shut_reg <= shut_reg;
            out_sleep_reg <= sleep_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= '0;
            pct_reg <= '0;
            chg_reg <= 1'b0;
            prior_reg <= '0;
            lg_reg <= '0;
            read_time_reg <= '0;
            push_time_reg <= '0;
            slot_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_v_reg[i] <= '0;
                hist_t_reg[i] <= '0;
            end
            seen_reg <= '0;
            run_reg <= '0;
            act_time_reg <= '0;
            shut_reg <= 1'b0;
            sleep_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            cv_reg <= cv_next;
            pct_reg <= pct_next;
            chg_reg <= chg_next;
            prior_reg <= prior_next;
            lg_reg <= lg_next;
            read_time_reg <= read_time_next;
            push_time_reg <= push_time_next;
            slot_reg <= slot_next;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_v_reg[i] <= hist_v_next[i];
                hist_t_reg[i] <= hist_t_next[i];
            end
            seen_reg <= seen_next;
            run_reg <= run_next;
            act_time_reg <= act_time_next;
            shut_reg <= shut_next;
            sleep_reg <= sleep_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        round_sum = {1'b0, prod_reg} + (READ_W+CAL_W+1)'(4096);
        raw_v = round_sum[READ_W+CAL_W:13];
        clamp_v = (raw_v > {3'b000, full_reg}) ? full_reg : raw_v[VOLT_W-1:0];
        spike_diff = (clamp_v >= lg_reg) ? clamp_v - lg_reg : lg_reg - clamp_v;
        meas_v = (lg_reg != '0 && spike_diff > SPIKE_MV) ? lg_reg : clamp_v;
        meas_chg = (action_reg == ACT_REFRESH) ? 1'b0 : chg_reg;
        span = full_reg - empty_reg;
        trial = {rem_reg, num_reg[NUM_W-1]};
        slot_eff = (32'(slot_reg) < HISTORY_DEPTH) ? slot_reg : '0;
        run_inc = (run_reg < RUN_MAX) ? run_reg + 8'd1 : run_reg;
        old_v = hist_v_reg[slot_reg];
        old_t = hist_t_reg[slot_reg];

        cv_next = cv_reg;
        pct_next = pct_reg;
        chg_next = chg_reg;
        prior_next = prior_reg;
        lg_next = lg_reg;
        read_time_next = read_time_reg;
        push_time_next = push_time_reg;
        slot_next = slot_reg;
        hist_v_next = hist_v_reg;
        hist_t_next = hist_t_reg;
        seen_next = seen_reg;
        run_next = run_reg;
        act_time_next = act_time_reg;
        shut_next = shut_reg;
        sleep_next = sleep_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;

        if (cmd.capture)
        begin
            shut_next = 1'b0;
            sleep_next = 1'b0;
        end

        if (cmd.apply)
        begin
            if (lg_reg == '0 || spike_diff <= SPIKE_MV)
            begin
                lg_next = clamp_v;
            end
            chg_next = meas_chg;
            if (prior_reg != '0 && {1'b0, meas_v} > {1'b0, prior_reg} + PLUG_MV)
            begin
                chg_next = 1'b1;
                seen_next = now_reg;
            end
            else if (prior_reg != '0 && {1'b0, meas_v} + UNPLUG_MV < {1'b0, prior_reg})
            begin
                chg_next = 1'b0;
            end
            prior_next = meas_v;
            cv_next = meas_v;
            read_time_next = now_reg;
        end

        if (cmd.pct_init)
        begin
            rem_next = '0;
            den_next = {span, 1'b0};
            if (cv_reg >= full_reg)
            begin
                pct_next = PCT_FULL;
                cnt_next = '0;
            end
            else if (cv_reg <= empty_reg)
            begin
                pct_next = '0;
                cnt_next = '0;
            end
            else
            begin
                num_next = NUM_W'(cv_reg - empty_reg) * NUM_W'(PCT_SCALE)
                           + NUM_W'(span);
                cnt_next = DIV_CNT_W'(NUM_W);
            end
        end

        if (cmd.div_step)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                pct_next = num_next[PCT_W-1:0];
            end
        end

        if (cmd.push)
        begin
            hist_v_next[slot_eff] = cv_reg;
            hist_t_next[slot_eff] = now_reg;
            slot_next = (slot_eff == SLOT_LAST) ? '0 : slot_eff + 1'b1;
            push_time_next = now_reg;
        end

        if (cmd.trend)
        begin
            if (old_t != '0 && (now_reg - old_t) >= TREND_AGE_MS)
            begin
                if ({1'b0, cv_reg} > {1'b0, old_v} + TREND_RISE_MV)
                begin
                    chg_next = 1'b1;
                    seen_next = now_reg;
                end
                else if (cv_reg < TREND_HIGH_MV
                         && {1'b0, cv_reg} + TREND_FALL_MV < {1'b0, old_v})
                begin
                    chg_next = 1'b0;
                end
            end
        end

        if (cmd.crit)
        begin
            if (seen_reg != '0 && (now_reg - seen_reg) < grace_reg)
            begin
                run_next = '0;
            end
            else if (cv_reg <= CRITICAL_MV && !chg_reg)
            begin
                run_next = run_inc;
                shut_next = (run_inc >= confirm_reg);
            end
            else
            begin
                run_next = '0;
            end
        end

        if (cmd.sleep)
        begin
            sleep_next = !shut_reg && sleep_tmo_reg != '0 && !chg_reg
                         && (now_reg - act_time_reg) >= sleep_limit_reg;
        end

        if (cmd.activity)
        begin
            act_time_next = now_reg;
        end

        if (cmd.init_fill)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_v_next[i] = cv_reg;
                hist_t_next[i] = now_reg;
            end
            push_time_next = now_reg;
            act_time_next = now_reg;
        end
    end

    assign status.action = action_reg;
    assign status.push_due = (now_reg - push_time_reg) >= hist_intv_reg;
    assign status.stale = (now_reg - read_time_reg) >= cache_dur_reg;
    assign status.div_done = (cnt_reg == '0);

    assign out_voltage_mv = out_v_reg;
    assign out_percent = out_pct_reg;
    assign out_charging = out_chg_reg;
    assign out_shutdown_request = out_shut_reg;
    assign out_sleep_request = out_sleep_reg;

endmodule

### bench/battery_monitor_charge_detect_tb.sv
// Self-checking testbench for the battery monitor with charge detection.
`timescale 1ns / 1ps

module battery_monitor_charge_detect_tb;

    localparam logic [2:0] ACT_CODE_MAX = 3'd7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int NUM_SETTINGS = 5;
    localparam int ITEMS_PER_SETTING = 340;

    typedef struct packed {
        logic [12:0] voltage_mv;
        logic [6:0] percent;
        logic charging;
        logic shutdown_request;
        logic sleep_request;
    } batt_status_s;

    class battery_status_predictor;
        bit [12:0] full_mv, empty_mv;
        bit [15:0] cal_q14;
        bit [31:0] push_interval, cache_age, grace_ms;
        bit [7:0] confirm_count;
        bit [15:0] sleep_min;

        bit [12:0] cached_v, prior_v, good_v;
        bit [6:0] cached_pct;
        bit cached_chg;
        bit [31:0] read_stamp, push_stamp, charge_stamp, activity_stamp;
        bit [2:0] slot;
        bit [12:0] hist_v[5];
        bit [31:0] hist_t[5];
        bit [7:0] low_run;

        batt_status_s expected_status[$];
        int mismatches;

        function void clear_state();
            full_mv = 4200; empty_mv = 3300; cal_q14 = 16384;
            push_interval = 30000; cache_age = 5000; grace_ms = 60000;
            confirm_count = 3; sleep_min = 0;
            cached_v = 0; prior_v = 0; good_v = 0; cached_pct = 0; cached_chg = 0;
            read_stamp = 0; push_stamp = 0; charge_stamp = 0; activity_stamp = 0;
            slot = 0; low_run = 0;
            for (int i = 0; i < 5; i++)
            begin
                hist_v[i] = 0;
                hist_t[i] = 0;
            end
            expected_status.delete();
            mismatches = 0;
        endfunction

        function void write_reg(bmcd_pkg::cfg_index_t idx, bit [31:0] value);
            case (idx)
                bmcd_pkg::CFG_FULL_MV:      full_mv = value[12:0];
                bmcd_pkg::CFG_EMPTY_MV:     empty_mv = value[12:0];
                bmcd_pkg::CFG_CALIBRATION:  cal_q14 = value[15:0];
                bmcd_pkg::CFG_HIST_INTV:    push_interval = value;
                bmcd_pkg::CFG_CACHE_DUR:    cache_age = value;
                bmcd_pkg::CFG_GRACE:        grace_ms = value;
                bmcd_pkg::CFG_CRIT_CONFIRM: confirm_count = value[7:0];
                bmcd_pkg::CFG_SLEEP_TMO:    sleep_min = value[15:0];
                default: ;
            endcase
        endfunction

        function bit [6:0] level_of(bit [31:0] v);
            bit [31:0] span;
            if (v >= full_mv) return 7'd100;
            if (v <= empty_mv) return 7'd0;
            span = full_mv - empty_mv;
            return 7'(((v - empty_mv) * 32'd200 + span) / (32'd2 * span));
        endfunction

        function void take_measurement(bit [31:0] now, bit [11:0] reading, bit restart);
            bit [31:0] v, diff;
            bit chg;
            v = (32'(reading) * 32'd2 * 32'(cal_q14) + 32'd8192) >> 14;
            if (v > full_mv) v = full_mv;
            if (good_v != 0)
            begin
                diff = (v > good_v) ? v - good_v : good_v - v;
                if (diff > 32'd500) v = good_v;
                else good_v = v[12:0];
            end
            else
                good_v = v[12:0];
            chg = restart ? 1'b0 : cached_chg;
            if (prior_v != 0 && v > 32'(prior_v) + 32'd250)
            begin
                chg = 1'b1;
                charge_stamp = now;
            end
            else if (prior_v != 0 && v + 32'd200 < 32'(prior_v))
                chg = 1'b0;
            prior_v = v[12:0];
            cached_v = v[12:0];
            cached_pct = level_of(v);
            cached_chg = chg;
            read_stamp = now;
        endfunction

        function void refresh_if_old(bit [31:0] now, bit [11:0] reading);
            if (now - read_stamp >= cache_age) take_measurement(now, reading, 1'b0);
        endfunction

        function void note_item(bit [2:0] action, bit [31:0] now, bit [11:0] reading);
            batt_status_s s;
            bit shut, doze;
            bit [2:0] k;
            bit [31:0] idle_age;
            longint unsigned idle_limit;
            shut = 0;
            doze = 0;
            case (action)
                bmcd_pkg::ACT_UPDATE:
                begin
                    if (now - push_stamp >= push_interval)
                    begin
                        k = (slot < 5) ? slot : 3'd0;
                        refresh_if_old(now, reading);
                        hist_v[k] = cached_v;
                        hist_t[k] = now;
                        k = (k + 3'd1) % 3'd5;
                        slot = k;
                        push_stamp = now;
                        if (hist_t[k] != 0 && now - hist_t[k] >= 32'd90000)
                        begin
                            if (32'(cached_v) > 32'(hist_v[k]) + 32'd30)
                            begin
                                cached_chg = 1'b1;
                                charge_stamp = now;
                            end
                            else if (cached_v < 13'd4000
                                     && 32'(cached_v) + 32'd90 < 32'(hist_v[k]))
                                cached_chg = 1'b0;
                        end
                    end
                    refresh_if_old(now, reading);
                    if (charge_stamp != 0 && now - charge_stamp < grace_ms)
                        low_run = 0;
                    else if (cached_v <= 13'd3000 && !cached_chg)
                    begin
                        if (low_run < 8'd255) low_run++;
                        if (low_run >= confirm_count) shut = 1'b1;
                    end
                    else
                        low_run = 0;
                    if (!shut && sleep_min != 0 && !cached_chg)
                    begin
                        idle_limit = longint'(sleep_min) * 60000;
                        idle_age = now - activity_stamp;
                        if (longint'(idle_age) >= idle_limit) doze = 1'b1;
                    end
                end
                bmcd_pkg::ACT_QUERY:    refresh_if_old(now, reading);
                bmcd_pkg::ACT_REFRESH:  take_measurement(now, reading, 1'b1);
                bmcd_pkg::ACT_ACTIVITY: activity_stamp = now;
                bmcd_pkg::ACT_INIT:
                begin
                    take_measurement(now, reading, 1'b0);
                    for (int i = 0; i < 5; i++)
                    begin
                        hist_v[i] = cached_v;
                        hist_t[i] = now;
                    end
                    push_stamp = now;
                    activity_stamp = now;
                end
                default: ;
            endcase
            s.voltage_mv = cached_v;
            s.percent = cached_pct;
            s.charging = cached_chg;
            s.shutdown_request = shut;
            s.sleep_request = doze;
            expected_status.push_back(s);
        endfunction

        function void check_status(batt_status_s got);
            batt_status_s want;
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected status %p", $time, got);
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            if (got.voltage_mv !== want.voltage_mv)
                $display("%0t: voltage_mv expected %0d got %0d", $time,
                         want.voltage_mv, got.voltage_mv);
            if (got.percent !== want.percent)
                $display("%0t: percent expected %0d got %0d", $time,
                         want.percent, got.percent);
            if (got.charging !== want.charging)
                $display("%0t: charging expected %0b got %0b", $time,
                         want.charging, got.charging);
            if (got.shutdown_request !== want.shutdown_request)
                $display("%0t: shutdown_request expected %0b got %0b", $time,
                         want.shutdown_request, got.shutdown_request);
            if (got.sleep_request !== want.sleep_request)
                $display("%0t: sleep_request expected %0b got %0b", $time,
                         want.sleep_request, got.sleep_request);
            if (got !== want) mismatches++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [bmcd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bmcd_pkg::CFG_DATA_W-1:0] cfg_data;

    bmcd_in_if in_ch();
    bmcd_out_if out_ch();

    battery_monitor_charge_detect dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item(in_ch.sink),
        .result(out_ch.source)
    );

    battery_status_predictor monitor_model;
    bit idle_on;
    bit long_hold_req;
    int cycle_count;
    bit [31:0] clock_ms;
    int batt_mv;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int hold;
        batt_status_s got;
        hold = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.voltage_mv = out_ch.voltage_mv;
                got.percent = out_ch.percent;
                got.charging = out_ch.charging;
                got.shutdown_request = out_ch.shutdown_request;
                got.sleep_request = out_ch.sleep_request;
                monitor_model.check_status(got);
                if (idle_on) hold = $urandom_range(0, 5);
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                hold--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(bit [2:0] action, bit [31:0] now, bit [11:0] reading);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= action;
        in_ch.now_ms <= now;
        in_ch.reading_mv <= reading;
        do
            @(posedge clk);
        while (!in_ch.ready);
        monitor_model.note_item(action, now, reading);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (monitor_model.expected_status.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(bmcd_pkg::cfg_index_t idx, bit [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        monitor_model.write_reg(idx, value);
    endtask

    task automatic apply_setting(int n);
        bit [31:0] r[8];
        case (n)
            0: r = '{4200, 3300, 16384, 30000, 5000, 60000, 3, 0};
            1: r = '{8191, 0, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255, 65535};
            2: r = '{0, 0, 0, 0, 0, 0, 0, 1};
            3: r = '{4200, 3300, 16384, 1000, 0, 5000, 2, 1};
            default: r = '{3000, 3500, 17000, 500, 100, 0, 1, 2};
        endcase
        write_reg(bmcd_pkg::CFG_FULL_MV, r[0]);
        write_reg(bmcd_pkg::CFG_EMPTY_MV, r[1]);
        write_reg(bmcd_pkg::CFG_CALIBRATION, r[2]);
        write_reg(bmcd_pkg::CFG_HIST_INTV, r[3]);
        write_reg(bmcd_pkg::CFG_CACHE_DUR, r[4]);
        write_reg(bmcd_pkg::CFG_GRACE, r[5]);
        write_reg(bmcd_pkg::CFG_CRIT_CONFIRM, r[6]);
        write_reg(bmcd_pkg::CFG_SLEEP_TMO, r[7]);
    endtask

    task automatic random_item(int step_max);
        int pick;
        bit [2:0] action;
        bit [11:0] reading;
        pick = $urandom_range(0, 99);
        if (pick < 60) action = bmcd_pkg::ACT_UPDATE;
        else if (pick < 72) action = bmcd_pkg::ACT_QUERY;
        else if (pick < 80) action = bmcd_pkg::ACT_REFRESH;
        else if (pick < 92) action = bmcd_pkg::ACT_ACTIVITY;
        else if (pick < 97) action = bmcd_pkg::ACT_INIT;
        else action = $urandom_range(bmcd_pkg::ACT_INIT + 1, ACT_CODE_MAX);

        pick = $urandom_range(0, 99);
        if (pick < 3) clock_ms = $urandom;
        else if (pick < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        else clock_ms = clock_ms + $urandom_range(0, step_max);

        pick = $urandom_range(0, 99);
        if (pick < 4) batt_mv += $urandom_range(260, 480);
        else if (pick < 8) batt_mv -= $urandom_range(210, 480);
        else batt_mv += $urandom_range(0, 40) - 22;
        if (batt_mv < 2600) batt_mv = 4100;
        if (batt_mv > 4400) batt_mv = 3000;

        pick = $urandom_range(0, 99);
        if (pick < 8) reading = 12'($urandom);
        else if (pick < 12) reading = 12'((batt_mv + $urandom_range(600, 1200)) / 2);
        else reading = 12'((batt_mv + $urandom_range(0, 20)) / 2);
        send_item(action, clock_ms, reading);
    endtask

    initial
    begin
        int step_max;
        monitor_model = new();
        monitor_model.clear_state();
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        cycle_count = 0;
        clock_ms = 0;
        batt_mv = 3800;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = '0;
        in_ch.now_ms = '0;
        in_ch.reading_mv = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(bmcd_pkg::ACT_QUERY, 32'd0, 12'd1900);
        send_item(bmcd_pkg::ACT_INIT, 32'd0, 12'd1900);
        send_item(bmcd_pkg::ACT_UPDATE, 32'd100, 12'd1900);
        send_item(bmcd_pkg::ACT_REFRESH, 32'd200, 12'hFFF);
        send_item(bmcd_pkg::ACT_REFRESH, 32'd300, 12'd0);
        send_item(bmcd_pkg::ACT_REFRESH, 32'd400, 12'd2000);
        send_item(bmcd_pkg::ACT_REFRESH, 32'd500, 12'd1850);
        send_item(bmcd_pkg::ACT_REFRESH, 32'd600, 12'd2000);
        send_item(bmcd_pkg::ACT_QUERY, 32'd5600, 12'd1880);
        send_item(bmcd_pkg::ACT_ACTIVITY, 32'd5700, 12'd0);
        send_item(3'd5, 32'd5800, 12'd1500);
        send_item(ACT_CODE_MAX, 32'd5900, 12'd1500);
        send_item(bmcd_pkg::ACT_REFRESH, 32'd6000, 12'd1550);
        send_item(bmcd_pkg::ACT_REFRESH, 32'd6100, 12'd1400);
        for (int i = 1; i <= 5; i++)
            send_item(bmcd_pkg::ACT_UPDATE, 32'd6000 + i * 31000, 12'd1400);
        send_item(bmcd_pkg::ACT_UPDATE, 32'hFFFF_FF00, 12'd1700);
        send_item(bmcd_pkg::ACT_UPDATE, 32'd50, 12'd2100);
        clock_ms = 32'd100;
        drain();

        for (int n = 0; n < NUM_SETTINGS; n++)
        begin
            apply_setting(n);
            step_max = (n >= 3) ? 3000 : 40000;
            for (int i = 0; i < ITEMS_PER_SETTING; i++)
            begin
                if (i < 30 || (i >= 150 && i < 200)) idle_on = 1'b0;
                else idle_on = 1'b1;
                if (n == 1 && i == 100) long_hold_req = 1'b1;
                if (n == 3 && i == 170)
                begin
                    in_ch.valid <= 1'b0;
                    while (monitor_model.expected_status.size() != 0) @(posedge clk);
                end
                random_item(step_max);
            end
            idle_on = 1'b1;
            drain();
        end

        if (monitor_model.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
src/bmcd_pkg.sv
src/bmcd_in_if.sv
src/bmcd_out_if.sv
src/bmcd_ctrl.sv
src/bmcd_datapath.sv
src/battery_monitor_charge_detect.sv
bench/battery_monitor_charge_detect_tb.sv
